@@ sv/bpc_pkg.sv @@
// bpc_pkg: shared types and constants for the barometric pressure compensation block
// holds result status codes, configuration register indexes and fixed-point widths
// no dependencies
package bpc_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_CAL  = 2'd1,
    ST_P_ZERO   = 2'd2,
    ST_T_ZERO   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_COEF_LOW  = 2'd0,
    REG_COEF_MID  = 2'd1,
    REG_COEF_HIGH = 2'd2,
    REG_CAL_VALID = 2'd3
  } cfg_reg_t;

  localparam int RAW_W   = 24;   // raw sensor reading
  localparam int CFG_W   = 48;   // packed calibration word
  localparam int PRES_W  = 32;   // pressure result, 1/64 Pa
  localparam int TEMP_W  = 24;   // temperature result, 1/256 degC

  // raw * 2^26 / (255 * 2^13) with round half up reduces to (raw * 2^13 + 127) / 255
  localparam int DIV_IN_W  = 38;
  localparam int PRE_SHIFT = 13;
  localparam int DIV_BIAS  = 127;
  localparam int DIV_REM_W = 14;  // remainder width after the first folding steps
  localparam int SC_W      = 30;  // scaled sample, Q26

  localparam int A_W    = 28;
  localparam int B_W    = 31;
  localparam int PP_W   = 33;
  localparam int TP_W   = 33;
  localparam int U_W    = 28;
  localparam int TC_W   = 28;
  localparam int TPU_W  = 32;
  localparam int PART_W = 33;
  localparam int TRAW_W = 26;
  localparam int SUM_W  = 35;

endpackage

@@ sv/barometric_pressure_compensation.sv @@
// barometric_pressure_compensation: pipelined pressure and temperature compensation
// scales raw samples, evaluates the calibration polynomial and saturates the results
// depends on bpc_pkg
//
// usage:
//   sample channel: raw_pressure_sample and raw_temperature_sample are taken at a rising
//   edge with sample_valid high and sample_stall low. result channel: pressure_out,
//   temperature_out and result_status form one word, taken when result_valid is high
//   and result_stall low. every sample word gives exactly one result word.
//   calibration is loaded through cfg_write / cfg_index / cfg_data; the user must do so while no
//   word is in flight, the block does not enforce it. calibration_valid must be set for status ok.
// timing:
//   six register stages: the scaled-sample divide by 255 is folded over the first two,
//   the Horner chain takes one multiplier stage per term after that. one word per cycle
//   is sustained while result_stall stays low.
// reset:
//   rst (synchronous) empties the pipeline and clears all calibration registers.
// stall:
//   a stalled result word holds; upstream stages keep filling empty slots, so the block
//   keeps accepting until all six stages are occupied, then raises sample_stall.
module barometric_pressure_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [bpc_pkg::RAW_W-1:0]    raw_pressure_sample,
  input  logic signed [bpc_pkg::RAW_W-1:0]    raw_temperature_sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [bpc_pkg::PRES_W-1:0]   pressure_out,
  output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_out,
  output logic [1:0]                          result_status
);

  // calibration registers
  logic [bpc_pkg::CFG_W-1:0] coef_low;
  logic [bpc_pkg::CFG_W-1:0] coef_mid;
  logic [bpc_pkg::CFG_W-1:0] coef_high;
  logic                      cal_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_low  <= '0;
      coef_mid  <= '0;
      coef_high <= '0;
      cal_valid <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        bpc_pkg::REG_COEF_LOW:  coef_low  <= cfg_data;
        bpc_pkg::REG_COEF_MID:  coef_mid  <= cfg_data;
        bpc_pkg::REG_COEF_HIGH: coef_high <= cfg_data;
        bpc_pkg::REG_CAL_VALID: cal_valid <= cfg_data[0];
        default:                cal_valid <= cal_valid;
      endcase
    end
  end

  // coefficient unpacking, first byte sits in the top bits of each word
  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  assign c0  = coef_low[47:36];
  assign c1  = coef_low[35:24];
  assign c00 = coef_low[23:4];
  assign c10 = {coef_low[3:0], coef_mid[47:32]};
  assign c01 = coef_mid[31:16];
  assign c11 = coef_mid[15:0];
  assign c20 = coef_high[47:32];
  assign c21 = coef_high[31:16];
  assign c30 = coef_high[15:0];

  // pipeline occupancy and flow control, empty slots collapse
  logic [5:0] stage_vld;
  logic [5:0] rdy;

  always_comb begin
    rdy[5] = !stage_vld[5] || !result_stall;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !stage_vld[k] || rdy[k+1];
    end
  end

  assign sample_stall = !rdy[0];
  assign result_valid = stage_vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      if (rdy[0]) begin
        stage_vld[0] <= sample_valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) begin
          stage_vld[k] <= stage_vld[k-1];
        end
      end
    end
  end

  // stage 1: status, pre-scale and first folding steps of the divide by 255
  // z = 256*h + l gives z/255 = h + (h + l)/255
  bpc_pkg::status_t                        st1, st1_next;
  logic signed [bpc_pkg::SC_W-1:0]         qp1, qt1, qp1_next, qt1_next;
  logic signed [bpc_pkg::DIV_REM_W-1:0]    zp1, zt1, zp1_next, zt1_next;

  always_comb begin
    logic signed [bpc_pkg::DIV_IN_W-1:0] zp, zt, hp, ht;
    zp = (bpc_pkg::DIV_IN_W'(raw_pressure_sample) <<< bpc_pkg::PRE_SHIFT)
         + bpc_pkg::DIV_IN_W'(bpc_pkg::DIV_BIAS);
    zt = (bpc_pkg::DIV_IN_W'(raw_temperature_sample) <<< bpc_pkg::PRE_SHIFT)
         + bpc_pkg::DIV_IN_W'(bpc_pkg::DIV_BIAS);
    qp1_next = '0;
    qt1_next = '0;
    for (int i = 0; i < 3; i++) begin
      hp = zp >>> 8;
      ht = zt >>> 8;
      qp1_next = qp1_next + bpc_pkg::SC_W'(hp);
      qt1_next = qt1_next + bpc_pkg::SC_W'(ht);
      zp = hp + {30'd0, zp[7:0]};
      zt = ht + {30'd0, zt[7:0]};
    end
    zp1_next = bpc_pkg::DIV_REM_W'(zp);
    zt1_next = bpc_pkg::DIV_REM_W'(zt);
    if (!cal_valid) begin
      st1_next = bpc_pkg::ST_NOT_CAL;
    end else if (raw_pressure_sample == '0) begin
      st1_next = bpc_pkg::ST_P_ZERO;
    end else if (raw_temperature_sample == '0) begin
      st1_next = bpc_pkg::ST_T_ZERO;
    end else begin
      st1_next = bpc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st1 <= st1_next;
      qp1 <= qp1_next;
      qt1 <= qt1_next;
      zp1 <= zp1_next;
      zt1 <= zt1_next;
    end
  end

  // stage 2: remaining folding steps, remainder ends in 0..255
  bpc_pkg::status_t                st2;
  logic signed [bpc_pkg::SC_W-1:0] p2, t2, p2_next, t2_next;

  always_comb begin
    logic signed [bpc_pkg::DIV_REM_W-1:0] zp, zt, hp, ht;
    zp = zp1;
    zt = zt1;
    p2_next = qp1;
    t2_next = qt1;
    for (int i = 0; i < 4; i++) begin
      hp = zp >>> 8;
      ht = zt >>> 8;
      p2_next = p2_next + bpc_pkg::SC_W'(hp);
      t2_next = t2_next + bpc_pkg::SC_W'(ht);
      zp = hp + {6'd0, zp[7:0]};
      zt = ht + {6'd0, zt[7:0]};
    end
    // a remainder of exactly 255 is one more whole quotient
    if (zp == bpc_pkg::DIV_REM_W'(255)) begin
      p2_next = p2_next + bpc_pkg::SC_W'(1);
    end
    if (zt == bpc_pkg::DIV_REM_W'(255)) begin
      t2_next = t2_next + bpc_pkg::SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      st2 <= st1;
      p2  <= p2_next;
      t2  <= t2_next;
    end
  end

  // stage 3: first products of the polynomial and the temperature product
  bpc_pkg::status_t                  st3;
  logic signed [bpc_pkg::SC_W-1:0]   p3;
  logic signed [bpc_pkg::A_W-1:0]    a3, a3_next;
  logic signed [bpc_pkg::TP_W-1:0]   tp3, tp3_next;
  logic signed [bpc_pkg::U_W-1:0]    u3, u3_next;
  logic signed [bpc_pkg::TC_W-1:0]   tc3, tc3_next;
  logic signed [bpc_pkg::TRAW_W-1:0] temp3, temp3_next;

  logic signed [45:0] m_pc30, m_pc21, m_tc01;
  logic signed [59:0] m_tp;
  logic signed [41:0] m_c1t;

  always_comb begin
    m_pc30 = 46'(p2) * 46'(c30);
    m_pc21 = 46'(p2) * 46'(c21);
    m_tc01 = 46'(t2) * 46'(c01);
    m_tp   = 60'(t2) * 60'(p2);
    m_c1t  = 42'(c1) * 42'(t2);
    a3_next    = bpc_pkg::A_W'((m_pc30 + (46'sd1 <<< 17)) >>> 18)
                 + (bpc_pkg::A_W'(c20) <<< 8);
    u3_next    = bpc_pkg::U_W'((m_pc21 + (46'sd1 <<< 17)) >>> 18)
                 + (bpc_pkg::U_W'(c11) <<< 8);
    tc3_next   = bpc_pkg::TC_W'((m_tc01 + (46'sd1 <<< 17)) >>> 18);
    tp3_next   = bpc_pkg::TP_W'((m_tp + (60'sd1 <<< 25)) >>> 26);
    temp3_next = bpc_pkg::TRAW_W'((m_c1t + (42'sd1 <<< 17)) >>> 18)
                 + (bpc_pkg::TRAW_W'(c0) <<< 7);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      st3   <= st2;
      p3    <= p2;
      a3    <= a3_next;
      tp3   <= tp3_next;
      u3    <= u3_next;
      tc3   <= tc3_next;
      temp3 <= temp3_next;
    end
  end

  // stage 4: second Horner step, the cross term and temperature saturation
  bpc_pkg::status_t                  st4;
  logic signed [bpc_pkg::SC_W-1:0]   p4;
  logic signed [bpc_pkg::B_W-1:0]    b4, b4_next;
  logic signed [bpc_pkg::TPU_W-1:0]  tpu4, tpu4_next;
  logic signed [bpc_pkg::PART_W-1:0] part4, part4_next;
  logic signed [bpc_pkg::TEMP_W-1:0] temp4, temp4_next;

  logic signed [57:0] m_pa;
  logic signed [60:0] m_tpu;

  always_comb begin
    m_pa  = 58'(p3) * 58'(a3);
    m_tpu = 61'(tp3) * 61'(u3);
    b4_next    = bpc_pkg::B_W'((m_pa + (58'sd1 <<< 25)) >>> 26)
                 + (bpc_pkg::B_W'(c10) <<< 8);
    tpu4_next  = bpc_pkg::TPU_W'((m_tpu + (61'sd1 <<< 25)) >>> 26);
    part4_next = bpc_pkg::PART_W'(tc3) + (bpc_pkg::PART_W'(c00) <<< 8);
    if (temp3 > bpc_pkg::TRAW_W'(8388607)) begin
      temp4_next = {1'b0, {(bpc_pkg::TEMP_W-1){1'b1}}};
    end else if (temp3 < -bpc_pkg::TRAW_W'(8388608)) begin
      temp4_next = {1'b1, {(bpc_pkg::TEMP_W-1){1'b0}}};
    end else begin
      temp4_next = bpc_pkg::TEMP_W'(temp3);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      st4   <= st3;
      p4    <= p3;
      b4    <= b4_next;
      tpu4  <= tpu4_next;
      part4 <= part4_next;
      temp4 <= temp4_next;
    end
  end

  // stage 5: last Horner step and the partial sum of the remaining terms
  bpc_pkg::status_t                  st5;
  logic signed [bpc_pkg::PP_W-1:0]   pp5, pp5_next;
  logic signed [bpc_pkg::PART_W-1:0] part5, part5_next;
  logic signed [bpc_pkg::TEMP_W-1:0] temp5;

  logic signed [60:0] m_pb;

  always_comb begin
    m_pb       = 61'(p4) * 61'(b4);
    pp5_next   = bpc_pkg::PP_W'((m_pb + (61'sd1 <<< 25)) >>> 26);
    part5_next = part4 + bpc_pkg::PART_W'(tpu4);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      st5   <= st4;
      pp5   <= pp5_next;
      part5 <= part5_next;
      temp5 <= temp4;
    end
  end

  // stage 6: final sum, rounding to 1/64 Pa, saturation, zeroing when status is not ok, and output word
  logic signed [bpc_pkg::SUM_W-1:0]  sum6, rsum6;
  logic signed [bpc_pkg::PRES_W-1:0] pres_next, pres_sat;
  logic signed [bpc_pkg::TEMP_W-1:0] temp_next;

  always_comb begin
    sum6  = bpc_pkg::SUM_W'(pp5) + bpc_pkg::SUM_W'(part5);
    rsum6 = (sum6 + bpc_pkg::SUM_W'(2)) >>> 2;
    if (rsum6 > bpc_pkg::SUM_W'(2147483647)) begin
      pres_sat = {1'b0, {(bpc_pkg::PRES_W-1){1'b1}}};
    end else if (rsum6 < -bpc_pkg::SUM_W'(64'sd2147483648)) begin
      pres_sat = {1'b1, {(bpc_pkg::PRES_W-1){1'b0}}};
    end else begin
      pres_sat = bpc_pkg::PRES_W'(rsum6);
    end
    if (st5 == bpc_pkg::ST_OK) begin
      pres_next = pres_sat;
      temp_next = temp5;
    end else begin
      pres_next = '0;
      temp_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      pressure_out    <= pres_next;
      temperature_out <= temp_next;
      result_status   <= st5;
    end
  end

endmodule
